// ===== src/chip_select_address_decoder_assert.svh =====
// assertion macros for the chip select address decoder
`ifndef CHIP_SELECT_ADDRESS_DECODER_ASSERT_SVH
`define CHIP_SELECT_ADDRESS_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define CSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/csd_pkg.sv =====
// types, constants and window function of the chip select address decoder
package csd_pkg;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned SETUP_W  = 24;
    localparam int unsigned NUM_CS   = 4;
    localparam int unsigned IDX_W    = 3;

    localparam logic [ADDR_W-1:0] INTERNAL_LIMIT = 24'h000FE0;

    localparam logic [7:0] CTRL_ENABLE   = 8'h80;
    localparam logic [7:0] CTRL_OVERRIDE = 8'h40;

    localparam logic [ADDR_W-1:0] MASK_CS0_MID = 24'h003F00;
    localparam logic [ADDR_W-1:0] MASK_CS1_MID = 24'h007F00;
    localparam logic [ADDR_W-1:0] MASK_LOW_WIDE = 24'h0001FF;
    localparam logic [ADDR_W-1:0] MASK_LOW_NARROW = 24'h0000FF;
    localparam logic [14:0]       MASK_HI_LOW = 15'h7FFF;

    localparam logic [SETUP_W-1:0] CS0_RESET = 24'h00FFFF;
    localparam logic [SETUP_W-1:0] CS1_RESET = 24'h00FFFF;
    localparam logic [SETUP_W-1:0] CS2_RESET = 24'h80FFFF;
    localparam logic [SETUP_W-1:0] CS3_RESET = 24'h00FFFF;
    localparam logic [NUM_CS-1:0]  SLOTS_RESET = 4'h0;

    typedef enum logic [IDX_W-1:0] {
        REG_CS0   = 3'd0,
        REG_CS1   = 3'd1,
        REG_CS2   = 3'd2,
        REG_CS3   = 3'd3,
        REG_SLOTS = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_CS0      = 3'd1,
        TGT_CS1      = 3'd2,
        TGT_CS2      = 3'd3,
        TGT_CS3      = 3'd4,
        TGT_NONE     = 3'd5
    } t_target;

    // last address of a select window
    function automatic logic [ADDR_W-1:0] window_end(
        input logic [1:0] sel,
        input logic [7:0] start_b,
        input logic [7:0] m
    );
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] start_a;
        start_a = {start_b, 16'h0000};
        if (sel == 2'd0) begin
            mask = {3'b000, m[7:2], 15'h0000};
            mask = mask | (m[1] ? MASK_CS0_MID : '0);
            mask = mask | (m[0] ? MASK_LOW_WIDE : MASK_LOW_NARROW);
        end else if (sel == 2'd1) begin
            mask = {2'b00, m[7:2], 16'h0000};
            mask = mask | (m[1] ? MASK_CS1_MID : '0);
            mask = mask | (m[0] ? MASK_LOW_WIDE : MASK_LOW_NARROW);
        end else begin
            mask = {1'b0, m, MASK_HI_LOW};
        end
        return start_a | mask;
    endfunction

endpackage

// ===== src/chip_select_address_decoder.sv =====
// chip select address decoder: one bus address in, one target out
// an accepted request is taken into the input register, then decoded into the result register with o_valid
// throughput: one request per cycle, busy never asserts
// stages: input register, then decode into the result register
// i_rst_n is synchronous active low; it restores the select setup registers
// and drops all pending requests; results cannot be stalled by the receiver
`include "chip_select_address_decoder_assert.svh"

module chip_select_address_decoder
    import csd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ADDR_W-1:0]   i_bus_address,
    output logic                o_valid,
    output logic [2:0]          o_target,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [SETUP_W-1:0]  i_cfg_data
);

    logic [SETUP_W-1:0] r_cs_setup [NUM_CS];
    logic [NUM_CS-1:0]  r_slots;

    logic               r_in_vld;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_out_vld;
    t_target            r_target;

    logic [NUM_CS-1:0]  hit;
    t_target            n_target;

    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_setup[0] <= CS0_RESET;
            r_cs_setup[1] <= CS1_RESET;
            r_cs_setup[2] <= CS2_RESET;
            r_cs_setup[3] <= CS3_RESET;
            r_slots       <= SLOTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CS0:   r_cs_setup[0] <= i_cfg_data;
                REG_CS1:   r_cs_setup[1] <= i_cfg_data;
                REG_CS2:   r_cs_setup[2] <= i_cfg_data;
                REG_CS3:   r_cs_setup[3] <= i_cfg_data;
                REG_SLOTS: r_slots       <= i_cfg_data[NUM_CS-1:0];
                default: ;
            endcase
        end
    end

    // per-select window match
    always_comb begin
        logic [7:0]        ctrl;
        logic [ADDR_W-1:0] w_start;
        logic [ADDR_W-1:0] w_end;
        for (int i = 0; i < NUM_CS; i++) begin
            ctrl    = r_cs_setup[i][23:16];
            w_start = {r_cs_setup[i][15:8], 16'h0000};
            w_end   = window_end(2'(i), r_cs_setup[i][15:8], r_cs_setup[i][7:0]);
            if (!r_slots[i] || (ctrl & CTRL_ENABLE) == 8'h00) begin
                hit[i] = 1'b0;
            end else if (i == 2 && (ctrl & CTRL_OVERRIDE) == 8'h00) begin
                hit[i] = 1'b1;
            end else begin
                hit[i] = (r_addr >= w_start) && (r_addr <= w_end);
            end
        end
    end

    // priority select
    always_comb begin
        if (r_addr < INTERNAL_LIMIT) begin
            n_target = TGT_INTERNAL;
        end else if (hit[0]) begin
            n_target = TGT_CS0;
        end else if (hit[1]) begin
            n_target = TGT_CS1;
        end else if (hit[2]) begin
            n_target = TGT_CS2;
        end else if (hit[3]) begin
            n_target = TGT_CS3;
        end else begin
            n_target = TGT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_addr <= i_bus_address;
        end
        if (r_in_vld) begin
            r_target <= n_target;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_target = r_target;

    `CSD_ASSERT_NXT(a_req_to_result, i_clk, i_rst_n, start, ##1 o_valid)
    `CSD_ASSERT_NXT(a_no_req_no_result, i_clk, i_rst_n, !start, ##1 !o_valid)
    `CSD_ASSERT_NXT(a_internal_first, i_clk, i_rst_n,
        r_in_vld && r_addr < INTERNAL_LIMIT, o_target == TGT_INTERNAL)
    `CSD_ASSERT_NXT(a_empty_slots_none, i_clk, i_rst_n,
        r_in_vld && r_slots == '0 && r_addr >= INTERNAL_LIMIT, o_target == TGT_NONE)
    `CSD_ASSERT_IMP(a_target_range, i_clk, i_rst_n, o_valid, o_target <= TGT_NONE)

endmodule

// ===== tb/tb_chip_select_address_decoder.sv =====
// self-checking testbench for the chip select address decoder
module tb_chip_select_address_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ADDR_W-1:0]   i_bus_address = '0;
    logic                o_valid;
    logic [2:0]          o_target;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic [SETUP_W-1:0]  i_cfg_data = '0;

    logic [SETUP_W-1:0]  cs_setup_copy [NUM_CS];
    logic [NUM_CS-1:0]   slots_copy;
    t_target             expected_targets [$];
    int unsigned         mismatch_count = 0;
    int unsigned         idle_pct = 0;

    chip_select_address_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_bus_address (i_bus_address),
        .o_valid       (o_valid),
        .o_target      (o_target),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] window_last(int unsigned sel,
                                                      logic [SETUP_W-1:0] setup);
        logic [7:0]        m;
        logic [ADDR_W-1:0] span;
        m = setup[7:0];
        case (sel)
            0: begin
                span = ({16'h0, m & 8'hFC} << 13) | (m[1] ? MASK_CS0_MID : '0)
                     | (m[0] ? MASK_LOW_WIDE : MASK_LOW_NARROW);
            end
            1: begin
                span = ({16'h0, m & 8'hFC} << 14) | (m[1] ? MASK_CS1_MID : '0)
                     | (m[0] ? MASK_LOW_WIDE : MASK_LOW_NARROW);
            end
            default: begin
                span = ({16'h0, m} << 15) | 24'h007FFF;
            end
        endcase
        return {setup[15:8], 16'h0000} | span;
    endfunction

    function automatic t_target predict_target(logic [ADDR_W-1:0] addr);
        logic [SETUP_W-1:0] s;
        logic [7:0]         ctrl;
        logic [ADDR_W-1:0]  lo;
        if (addr < INTERNAL_LIMIT)
            return TGT_INTERNAL;
        for (int i = 0; i < NUM_CS; i++) begin
            s = cs_setup_copy[i];
            ctrl = s[23:16];
            lo = {s[15:8], 16'h0000};
            if (slots_copy[i] && (ctrl & CTRL_ENABLE) != 0) begin
                if (i == 2 && (ctrl & CTRL_OVERRIDE) == 0)
                    return t_target'(TGT_CS0 + i);
                if (addr >= lo && addr <= window_last(i, s))
                    return t_target'(TGT_CS0 + i);
            end
        end
        return TGT_NONE;
    endfunction

    // addresses aimed at window edges, the internal limit, or anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       sel;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        sel = $urandom_range(NUM_CS - 1);
        lo = {cs_setup_copy[sel][15:8], 16'h0000};
        hi = window_last(sel, cs_setup_copy[sel]);
        case ($urandom_range(9))
            0: return ADDR_W'($urandom);
            1: return INTERNAL_LIMIT - ADDR_W'(2) + ADDR_W'($urandom_range(3));
            2: return ADDR_W'($urandom_range(INTERNAL_LIMIT));
            3: return lo;
            4: return hi;
            5: return lo - 1'b1;
            6: return hi + 1'b1;
            default: return lo | (ADDR_W'($urandom) & hi);
        endcase
    endfunction

    task automatic write_register(logic [IDX_W-1:0] idx, logic [SETUP_W-1:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_targets.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_CS3)
            cs_setup_copy[idx[1:0]] = data;
        else if (idx == REG_SLOTS)
            slots_copy = data[NUM_CS-1:0];
    endtask

    task automatic send_request(logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_bus_address <= addr;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        expected_targets.push_back(predict_target(addr));
    endtask

    task automatic finish_requests();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_targets.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic randomize_setup(int unsigned mode);
        logic [SETUP_W-1:0] v;
        logic [7:0]         ctrl;
        for (int i = 0; i < NUM_CS; i++) begin
            case (mode)
                0: v = '1;
                1: v = {CTRL_ENABLE, 16'h0000};
                default: begin
                    ctrl = 8'($urandom);
                    if ($urandom_range(3) != 0)
                        ctrl = ctrl | CTRL_ENABLE;
                    if ($urandom_range(3) != 0)
                        ctrl = ctrl | CTRL_OVERRIDE;
                    v = {ctrl, 16'($urandom)};
                end
            endcase
            write_register(IDX_W'(REG_CS0 + i), v);
        end
        if (mode == 0)
            write_register(REG_SLOTS, {20'($urandom), 4'hF});
        else if (mode == 1)
            write_register(REG_SLOTS, {20'h0, 4'hF});
        else
            write_register(REG_SLOTS, SETUP_W'($urandom));
        if ($urandom_range(3) == 0)
            write_register(IDX_W'(REG_SLOTS + $urandom_range(1, 3)), SETUP_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_request(24'h000000);
        send_request(INTERNAL_LIMIT - 1'b1);
        send_request(INTERNAL_LIMIT);
        send_request(24'hFFFFFF);
        finish_requests();
    endtask

    task automatic test_select_windows();
        // stray high bits on the slot mask, select 2 catches everything
        write_register(REG_SLOTS, 24'hABCDE5);
        send_request(24'h123456);
        write_register(REG_CS0, {8'h80, 8'h10, 8'h03});
        send_request(24'h100000);
        send_request(24'h103FFF);
        send_request(24'h104000);
        send_request(24'h0FFFFF);
        write_register(REG_CS2, {8'hC0, 8'h20, 8'h00});
        send_request(24'h207FFF);
        send_request(24'h208000);
        // start not aligned to the window
        write_register(REG_SLOTS, 24'h00000F);
        write_register(REG_CS1, {8'h80, 8'h30, 8'hFE});
        send_request(24'h300000);
        send_request(24'h3F7FFF);
        send_request(24'h3F8000);
        // control bits without enable
        write_register(REG_CS3, {8'h7F, 8'h40, 8'h01});
        send_request(24'h400000);
        write_register(REG_CS3, {8'hFF, 8'hFF, 8'hFF});
        send_request(24'hFFFFFF);
        send_request(24'hFF0000);
        send_request(24'hFEFFFF);
        // override bit ignored on select 0
        write_register(REG_CS0, {8'hC0, 8'h50, 8'h00});
        send_request(24'h5000FF);
        send_request(24'h500100);
        write_register(IDX_W'(REG_SLOTS + 1), 24'h000000);
        send_request(24'h500000);
        // priority among overlapping windows
        write_register(REG_CS3, {8'h80, 8'h30, 8'h00});
        send_request(24'h300001);
        write_register(REG_CS0, {8'h80, 8'h30, 8'h00});
        send_request(24'h300000);
        finish_requests();
    endtask

    task automatic test_random_traffic(int unsigned pct);
        idle_pct = pct;
        for (int unsigned blk = 0; blk < 8; blk++) begin
            randomize_setup(blk);
            repeat (60) send_request(pick_address());
            finish_requests();
        end
    endtask

    always @(posedge i_clk) begin
        t_target want;
        if (i_rst_n && o_valid) begin
            if (expected_targets.size() == 0) begin
                $error("target: expected no request result, got %0d", o_target);
                mismatch_count++;
            end else begin
                want = expected_targets.pop_front();
                if (o_target !== want) begin
                    $error("target: expected %0d, got %0d", want, o_target);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        cs_setup_copy = '{CS0_RESET, CS1_RESET, CS2_RESET, CS3_RESET};
        slots_copy = SLOTS_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_select_windows();
        test_random_traffic(0);
        test_random_traffic(53);
        test_random_traffic(0);
        test_random_traffic(8);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
